### src/sm83_pkg.sv
// ----------------------------------------------------------------------------
// SM83 core package
// Shared payload types, codes and constants for the instruction core.
// ----------------------------------------------------------------------------
package sm83_pkg;

    typedef struct packed {
        logic       action;
        logic [7:0] read_data;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [4:0]  cycles;
        logic        last;
        logic [15:0] snap_af;
        logic [15:0] snap_bc;
        logic [15:0] snap_de;
        logic [15:0] snap_hl;
        logic [15:0] snap_sp;
        logic [15:0] snap_pc;
    } out_word_t;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_FAULT = 2'd3;

    localparam logic ACT_BEGIN   = 1'b0;
    localparam logic ACT_DELIVER = 1'b1;

    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_OPC  = 3'd1;
    localparam logic [2:0] PH_CB   = 3'd2;
    localparam logic [2:0] PH_IMM1 = 3'd3;
    localparam logic [2:0] PH_IMM2 = 3'd4;
    localparam logic [2:0] PH_DAT1 = 3'd5;
    localparam logic [2:0] PH_DAT2 = 3'd6;

    localparam logic [3:0] FZ = 4'h8;
    localparam logic [3:0] FN = 4'h4;
    localparam logic [3:0] FH = 4'h2;
    localparam logic [3:0] FC = 4'h1;

    localparam logic [15:0] HIGH_PAGE = 16'hFF00;
    localparam logic [15:0] BOOT_SP   = 16'hFFFE;
    localparam logic [15:0] BOOT_PC   = 16'h0100;

    localparam logic ADDR_BOOT_STATE = 1'b0;

    // Full architectural state carried between words
    typedef struct packed {
        logic [7:0]  a;
        logic [3:0]  f;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] pc;
        logic [15:0] sp;
        logic        halt;
        logic        fault;
        logic [2:0]  phase;
        logic [8:0]  op;
        logic [7:0]  opl;
    } core_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [4:0]  cycles;
    } res_slot_t;

    function automatic core_state_t init_state(input logic boot);
        core_state_t s;
        s = '0;
        if (boot)
        begin
            s.a  = 8'h01;
            s.f  = 4'hB;
            s.c  = 8'h13;
            s.e  = 8'hD8;
            s.h  = 8'h01;
            s.l  = 8'h4D;
            s.pc = BOOT_PC;
            s.sp = BOOT_SP;
        end
        return s;
    endfunction

endpackage

### src/sm83_exec.sv
// ----------------------------------------------------------------------------
// SM83 execution step
// Combinational step: one input word against the current state gives the
// next state and up to three results (slots), with a count.
// ----------------------------------------------------------------------------
module sm83_exec (
    input  sm83_pkg::core_state_t st,
    input  logic                  action,
    input  logic [7:0]            din,
    output sm83_pkg::core_state_t ns,
    output sm83_pkg::res_slot_t   slot0,
    output sm83_pkg::res_slot_t   slot1,
    output sm83_pkg::res_slot_t   slot2,
    output logic [1:0]            count
);

    sm83_pkg::res_slot_t sl [3];
    logic [1:0] n;

    function automatic logic [7:0] get_r(input sm83_pkg::core_state_t s, input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0: v = s.b;
            3'd1: v = s.c;
            3'd2: v = s.d;
            3'd3: v = s.e;
            3'd4: v = s.h;
            3'd5: v = s.l;
            3'd7: v = s.a;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic sm83_pkg::core_state_t put_r(input sm83_pkg::core_state_t s,
        input logic [2:0] i, input logic [7:0] v);
        sm83_pkg::core_state_t o;
        o = s;
        case (i)
            3'd0: o.b = v;
            3'd1: o.c = v;
            3'd2: o.d = v;
            3'd3: o.e = v;
            3'd4: o.h = v;
            3'd5: o.l = v;
            3'd7: o.a = v;
            default: o = s;
        endcase
        return o;
    endfunction

    function automatic logic [15:0] pget(input sm83_pkg::core_state_t s, input logic [1:0] p);
        logic [15:0] v;
        case (p)
            2'd0: v = {s.b, s.c};
            2'd1: v = {s.d, s.e};
            2'd2: v = {s.h, s.l};
            default: v = s.sp;
        endcase
        return v;
    endfunction

    function automatic sm83_pkg::core_state_t pput(input sm83_pkg::core_state_t s,
        input logic [1:0] p, input logic [15:0] v);
        sm83_pkg::core_state_t o;
        o = s;
        case (p)
            2'd0: {o.b, o.c} = v;
            2'd1: {o.d, o.e} = v;
            2'd2: {o.h, o.l} = v;
            default: o.sp = v;
        endcase
        return o;
    endfunction

    function automatic logic cond_ok(input logic [3:0] f, input logic [7:0] op);
        logic r;
        if (op == 8'h18 || op == 8'hC3 || op == 8'hC9)
            r = 1'b1;
        else
        begin
            case (op[4:3])
                2'd0: r = !f[3];
                2'd1: r = f[3];
                2'd2: r = !f[0];
                default: r = f[0];
            endcase
        end
        return r;
    endfunction

    // 8-bit ALU: returns {flags, acc}
    function automatic logic [11:0] arith(input logic [2:0] sel, input logic [7:0] a,
        input logic [7:0] v, input logic [3:0] f);
        logic       cy;
        logic [8:0] s;
        logic [4:0] hs;
        logic [7:0] r;
        logic [3:0] nf;
        cy = f[0];
        r  = a;
        nf = f;
        case (sel)
            3'd0:
            begin
                s  = {1'b0, a} + {1'b0, v};
                hs = {1'b0, a[3:0]} + {1'b0, v[3:0]};
                r  = s[7:0];
                nf = {r == 8'h00, 1'b0, hs[4], s[8]};
            end
            3'd1:
            begin
                s  = {1'b0, a} + {1'b0, v} + {8'h00, cy};
                hs = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'h0, cy};
                r  = s[7:0];
                nf = {r == 8'h00, 1'b0, hs[4], s[8]};
            end
            3'd2, 3'd7:
            begin
                s  = {1'b0, a} - {1'b0, v};
                hs = {1'b0, a[3:0]} - {1'b0, v[3:0]};
                if (sel == 3'd2)
                    r = s[7:0];
                nf = {a == v, 1'b1, hs[4], s[8]};
            end
            3'd3:
            begin
                s  = {1'b0, a} - {1'b0, v} - {8'h00, cy};
                hs = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'h0, cy};
                r  = s[7:0];
                nf = {r == 8'h00, 1'b1, hs[4], s[8]};
            end
            3'd4:
            begin
                r  = a & v;
                nf = {r == 8'h00, 1'b0, 1'b1, 1'b0};
            end
            3'd5:
            begin
                r  = a ^ v;
                nf = {r == 8'h00, 3'b000};
            end
            default:
            begin
                r  = a | v;
                nf = {r == 8'h00, 3'b000};
            end
        endcase
        return {nf, r};
    endfunction

    // CB group: returns {flags, value}
    function automatic logic [11:0] cb_exec(input logic [7:0] op, input logic [7:0] vin,
        input logic [3:0] f);
        logic [2:0] bt;
        logic       cy;
        logic       oc;
        logic [7:0] v;
        logic [3:0] nf;
        bt = op[5:3];
        oc = f[0];
        cy = 1'b0;
        v  = vin;
        nf = f;
        case (op[7:6])
            2'd0:
            begin
                case (bt)
                    3'd0: begin cy = v[7]; v = {v[6:0], v[7]}; end
                    3'd1: begin cy = v[0]; v = {v[0], v[7:1]}; end
                    3'd2: begin cy = v[7]; v = {v[6:0], oc}; end
                    3'd3: begin cy = v[0]; v = {oc, v[7:1]}; end
                    3'd4: begin cy = v[7]; v = {v[6:0], 1'b0}; end
                    3'd5: begin cy = v[0]; v = {v[7], v[7:1]}; end
                    3'd6: v = {v[3:0], v[7:4]};
                    default: begin cy = v[0]; v = {1'b0, v[7:1]}; end
                endcase
                nf = {v == 8'h00, 2'b00, cy};
            end
            2'd1: nf = {!vin[bt], 1'b0, 1'b1, oc};
            2'd2: v = vin & ~(8'h01 << bt);
            default: v = vin | (8'h01 << bt);
        endcase
        return {nf, v};
    endfunction

    always_comb
    begin
        sm83_pkg::core_state_t s;
        logic [7:0]  op;
        logic [2:0]  r;
        logic [2:0]  sx3;
        logic [1:0]  p;
        logic [15:0] hlv;
        logic [15:0] sxt;
        logic [15:0] addr;
        logic [15:0] v16;
        logic [16:0] sum17;
        logic [12:0] h13;
        logic [11:0] ar;
        logic [7:0]  v8;
        logic [4:0]  h5;
        logic [8:0]  c9;
        logic [1:0]  k;
        logic [4:0]  cyc;
        logic        fin;
        logic        flt;
        s   = st;
        n   = 2'd0;
        sl[0] = '0;
        sl[1] = '0;
        sl[2] = '0;
        fin = 1'b0;
        flt = 1'b0;
        cyc = 5'd0;
        k   = 2'd0;
        op  = st.op[7:0];
        r   = op[5:3];
        sx3 = op[2:0];
        p   = op[5:4];
        hlv = {st.h, st.l};
        sxt = {{8{din[7]}}, din};
        addr = {din, st.opl};
        v16 = 16'h0;
        sum17 = 17'h0;
        h13 = 13'h0;
        ar  = 12'h0;
        v8  = 8'h0;
        h5  = 5'h0;
        c9  = 9'h0;

        if (action == sm83_pkg::ACT_BEGIN)
        begin
            if (st.fault)
                flt = 1'b1;
            else if (st.phase != sm83_pkg::PH_IDLE)
                s = st;
            else if (st.halt)
            begin
                sl[0] = '{sm83_pkg::KIND_DONE, 16'h0, 8'h0, 5'd4};
                n = 2'd1;
            end
            else
            begin
                sl[0] = '{sm83_pkg::KIND_READ, st.pc, 8'h0, 5'd0};
                n = 2'd1;
                s.pc = st.pc + 16'd1;
                s.phase = sm83_pkg::PH_OPC;
            end
        end
        else if (!st.fault)
        begin
            case (st.phase)
                sm83_pkg::PH_OPC:
                begin
                    op  = din;
                    r   = op[5:3];
                    sx3 = op[2:0];
                    p   = op[5:4];
                    s.op = {1'b0, din};
                    if (op == 8'h00)
                        begin fin = 1'b1; cyc = 5'd4; end
                    else if (op == 8'h76)
                        begin s.halt = 1'b1; fin = 1'b1; cyc = 5'd4; end
                    else if (op == 8'hCB)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, st.pc, 8'h0, 5'd0}; n = 2'd1;
                        s.pc = st.pc + 16'd1; s.phase = sm83_pkg::PH_CB;
                    end
                    else if (op[7:6] == 2'b01)
                    begin
                        if (sx3 == 3'd6)
                        begin
                            sl[0] = '{sm83_pkg::KIND_READ, hlv, 8'h0, 5'd0}; n = 2'd1;
                            s.phase = sm83_pkg::PH_DAT1;
                        end
                        else if (r == 3'd6)
                        begin
                            sl[0] = '{sm83_pkg::KIND_WRITE, hlv, get_r(st, sx3), 5'd0}; n = 2'd1;
                            fin = 1'b1; cyc = 5'd8;
                        end
                        else
                        begin
                            s = put_r(st, r, get_r(st, sx3)); s.op = {1'b0, din};
                            fin = 1'b1; cyc = 5'd4;
                        end
                    end
                    else if (op[7:6] == 2'b10)
                    begin
                        if (sx3 == 3'd6)
                        begin
                            sl[0] = '{sm83_pkg::KIND_READ, hlv, 8'h0, 5'd0}; n = 2'd1;
                            s.phase = sm83_pkg::PH_DAT1;
                        end
                        else
                        begin
                            ar = arith(r, st.a, get_r(st, sx3), st.f);
                            s.a = ar[7:0]; s.f = ar[11:8];
                            fin = 1'b1; cyc = 5'd4;
                        end
                    end
                    else if ((op & 8'hC7) == 8'h06 || (op & 8'hC7) == 8'hC6
                        || (op & 8'hCF) == 8'h01 || op == 8'h18 || op == 8'h20
                        || op == 8'h28 || op == 8'h30 || op == 8'h38 || op == 8'hC3
                        || op == 8'hC2 || op == 8'hCA || op == 8'hD2 || op == 8'hDA
                        || op == 8'hCD || op == 8'hF0 || op == 8'hFA || op == 8'hE0
                        || op == 8'hEA || op == 8'h08 || op == 8'hE8 || op == 8'hF8)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, st.pc, 8'h0, 5'd0}; n = 2'd1;
                        s.pc = st.pc + 16'd1; s.phase = sm83_pkg::PH_IMM1;
                    end
                    else if ((op & 8'hC7) == 8'h04 || (op & 8'hC7) == 8'h05)
                    begin
                        if (r == 3'd6)
                        begin
                            sl[0] = '{sm83_pkg::KIND_READ, hlv, 8'h0, 5'd0}; n = 2'd1;
                            s.phase = sm83_pkg::PH_DAT1;
                        end
                        else
                        begin
                            v8 = get_r(st, r);
                            if (sx3 == 3'd4)
                            begin
                                s = put_r(st, r, v8 + 8'd1);
                                s.f = {v8 == 8'hFF, 1'b0, v8[3:0] == 4'hF, st.f[0]};
                            end
                            else
                            begin
                                s = put_r(st, r, v8 - 8'd1);
                                s.f = {v8 == 8'h01, 1'b1, v8[3:0] == 4'h0, st.f[0]};
                            end
                            s.op = {1'b0, din};
                            fin = 1'b1; cyc = 5'd4;
                        end
                    end
                    else if ((op & 8'hCF) == 8'h03)
                    begin
                        s = pput(st, p, pget(st, p) + 16'd1); s.op = {1'b0, din};
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if ((op & 8'hCF) == 8'h0B)
                    begin
                        s = pput(st, p, pget(st, p) - 16'd1); s.op = {1'b0, din};
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if ((op & 8'hCF) == 8'h09)
                    begin
                        v16 = pget(st, p);
                        sum17 = {1'b0, hlv} + {1'b0, v16};
                        h13 = {1'b0, hlv[11:0]} + {1'b0, v16[11:0]};
                        s.f = {st.f[3], 1'b0, h13[12], sum17[16]};
                        {s.h, s.l} = sum17[15:0];
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if ((op & 8'hCF) == 8'hC5)
                    begin
                        v16 = (p == 2'd3) ? {st.a, st.f, 4'h0} : pget(st, p);
                        sl[0] = '{sm83_pkg::KIND_WRITE, st.sp - 16'd1, v16[15:8], 5'd0};
                        sl[1] = '{sm83_pkg::KIND_WRITE, st.sp - 16'd2, v16[7:0], 5'd0};
                        n = 2'd2;
                        s.sp = st.sp - 16'd2;
                        fin = 1'b1; cyc = 5'd16;
                    end
                    else if ((op & 8'hCF) == 8'hC1)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, st.sp, 8'h0, 5'd0}; n = 2'd1;
                        s.sp = st.sp + 16'd1; s.phase = sm83_pkg::PH_DAT1;
                    end
                    else if (op == 8'hC9 || op == 8'hC0 || op == 8'hC8 || op == 8'hD0
                        || op == 8'hD8)
                    begin
                        if (cond_ok(st.f, op))
                        begin
                            sl[0] = '{sm83_pkg::KIND_READ, st.sp, 8'h0, 5'd0}; n = 2'd1;
                            s.sp = st.sp + 16'd1; s.phase = sm83_pkg::PH_DAT1;
                        end
                        else
                        begin
                            fin = 1'b1; cyc = 5'd8;
                        end
                    end
                    else if (op == 8'h0A || op == 8'h1A || op == 8'h2A || op == 8'h3A
                        || op == 8'hF2)
                    begin
                        case (op)
                            8'h0A: v16 = {st.b, st.c};
                            8'h1A: v16 = {st.d, st.e};
                            8'hF2: v16 = sm83_pkg::HIGH_PAGE | {8'h00, st.c};
                            default: v16 = hlv;
                        endcase
                        sl[0] = '{sm83_pkg::KIND_READ, v16, 8'h0, 5'd0}; n = 2'd1;
                        if (op == 8'h2A) {s.h, s.l} = hlv + 16'd1;
                        if (op == 8'h3A) {s.h, s.l} = hlv - 16'd1;
                        s.phase = sm83_pkg::PH_DAT1;
                    end
                    else if (op == 8'h02 || op == 8'h12 || op == 8'h22 || op == 8'h32
                        || op == 8'hE2)
                    begin
                        case (op)
                            8'h02: v16 = {st.b, st.c};
                            8'h12: v16 = {st.d, st.e};
                            8'hE2: v16 = sm83_pkg::HIGH_PAGE | {8'h00, st.c};
                            default: v16 = hlv;
                        endcase
                        sl[0] = '{sm83_pkg::KIND_WRITE, v16, st.a, 5'd0}; n = 2'd1;
                        if (op == 8'h22) {s.h, s.l} = hlv + 16'd1;
                        if (op == 8'h32) {s.h, s.l} = hlv - 16'd1;
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if (op == 8'h07 || op == 8'h0F || op == 8'h17 || op == 8'h1F
                        || op == 8'h27 || op == 8'h2F || op == 8'h37 || op == 8'h3F)
                    begin
                        case (op)
                            8'h07: begin s.a = {st.a[6:0], st.a[7]}; s.f = {3'b000, st.a[7]}; end
                            8'h0F: begin s.a = {st.a[0], st.a[7:1]}; s.f = {3'b000, st.a[0]}; end
                            8'h17: begin s.a = {st.a[6:0], st.f[0]}; s.f = {3'b000, st.a[7]}; end
                            8'h1F: begin s.a = {st.f[0], st.a[7:1]}; s.f = {3'b000, st.a[0]}; end
                            8'h2F: begin s.a = ~st.a; s.f = st.f | sm83_pkg::FN | sm83_pkg::FH; end
                            8'h37: s.f = (st.f & sm83_pkg::FZ) | sm83_pkg::FC;
                            8'h3F: s.f = {st.f[3], 2'b00, !st.f[0]};
                            default: s.f = st.f;
                        endcase
                        fin = 1'b1; cyc = 5'd4;
                    end
                    else if (op == 8'hF9)
                    begin
                        s.sp = hlv; fin = 1'b1; cyc = 5'd8;
                    end
                    else
                        flt = 1'b1;
                end
                sm83_pkg::PH_CB:
                begin
                    s.op = {1'b1, din};
                    if (din[2:0] == 3'd6)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, hlv, 8'h0, 5'd0}; n = 2'd1;
                        s.phase = sm83_pkg::PH_DAT1;
                    end
                    else
                    begin
                        ar = cb_exec(din, get_r(st, din[2:0]), st.f);
                        s = put_r(st, din[2:0], ar[7:0]);
                        s.op = {1'b1, din};
                        s.f = ar[11:8];
                        fin = 1'b1; cyc = 5'd8;
                    end
                end
                sm83_pkg::PH_IMM1:
                begin
                    s.opl = din;
                    if ((op & 8'hC7) == 8'h06)
                    begin
                        if (r == 3'd6)
                        begin
                            sl[0] = '{sm83_pkg::KIND_WRITE, hlv, din, 5'd0}; n = 2'd1;
                            fin = 1'b1; cyc = 5'd12;
                        end
                        else
                        begin
                            s = put_r(st, r, din); s.opl = din;
                            fin = 1'b1; cyc = 5'd8;
                        end
                    end
                    else if ((op & 8'hC7) == 8'hC6)
                    begin
                        ar = arith(r, st.a, din, st.f);
                        s.a = ar[7:0]; s.f = ar[11:8];
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if (op == 8'h18 || op == 8'h20 || op == 8'h28 || op == 8'h30
                        || op == 8'h38)
                    begin
                        if (cond_ok(st.f, op))
                        begin
                            s.pc = st.pc + sxt; fin = 1'b1; cyc = 5'd12;
                        end
                        else
                        begin
                            fin = 1'b1; cyc = 5'd8;
                        end
                    end
                    else if (op == 8'hF0)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, sm83_pkg::HIGH_PAGE | {8'h00, din},
                            8'h0, 5'd0};
                        n = 2'd1; s.phase = sm83_pkg::PH_DAT1;
                    end
                    else if (op == 8'hE0)
                    begin
                        sl[0] = '{sm83_pkg::KIND_WRITE, sm83_pkg::HIGH_PAGE | {8'h00, din},
                            st.a, 5'd0};
                        n = 2'd1; fin = 1'b1; cyc = 5'd12;
                    end
                    else if (op == 8'hE8 || op == 8'hF8)
                    begin
                        h5 = {1'b0, st.sp[3:0]} + {1'b0, din[3:0]};
                        c9 = {1'b0, st.sp[7:0]} + {1'b0, din};
                        s.f = {2'b00, h5[4], c9[8]};
                        v16 = st.sp + sxt;
                        if (op == 8'hE8)
                        begin
                            s.sp = v16; fin = 1'b1; cyc = 5'd16;
                        end
                        else
                        begin
                            {s.h, s.l} = v16; fin = 1'b1; cyc = 5'd12;
                        end
                    end
                    else
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, st.pc, 8'h0, 5'd0}; n = 2'd1;
                        s.pc = st.pc + 16'd1; s.phase = sm83_pkg::PH_IMM2;
                    end
                end
                sm83_pkg::PH_IMM2:
                begin
                    if ((op & 8'hCF) == 8'h01)
                    begin
                        s = pput(st, p, addr); fin = 1'b1; cyc = 5'd12;
                    end
                    else if (op == 8'hCD)
                    begin
                        sl[0] = '{sm83_pkg::KIND_WRITE, st.sp - 16'd1, st.pc[15:8], 5'd0};
                        sl[1] = '{sm83_pkg::KIND_WRITE, st.sp - 16'd2, st.pc[7:0], 5'd0};
                        n = 2'd2;
                        s.sp = st.sp - 16'd2; s.pc = addr;
                        fin = 1'b1; cyc = 5'd24;
                    end
                    else if (op == 8'hFA)
                    begin
                        sl[0] = '{sm83_pkg::KIND_READ, addr, 8'h0, 5'd0}; n = 2'd1;
                        s.phase = sm83_pkg::PH_DAT1;
                    end
                    else if (op == 8'hEA)
                    begin
                        sl[0] = '{sm83_pkg::KIND_WRITE, addr, st.a, 5'd0}; n = 2'd1;
                        fin = 1'b1; cyc = 5'd16;
                    end
                    else if (op == 8'h08)
                    begin
                        sl[0] = '{sm83_pkg::KIND_WRITE, addr, st.sp[7:0], 5'd0};
                        sl[1] = '{sm83_pkg::KIND_WRITE, addr + 16'd1, st.sp[15:8], 5'd0};
                        n = 2'd2; fin = 1'b1; cyc = 5'd16;
                    end
                    else if (cond_ok(st.f, op))
                    begin
                        s.pc = addr; fin = 1'b1; cyc = 5'd16;
                    end
                    else
                    begin
                        fin = 1'b1; cyc = 5'd12;
                    end
                end
                sm83_pkg::PH_DAT1:
                begin
                    if (st.op[8])
                    begin
                        ar = cb_exec(op, din, st.f);
                        s.f = ar[11:8];
                        if (op[7:6] == 2'b01)
                        begin
                            fin = 1'b1; cyc = 5'd12;
                        end
                        else
                        begin
                            sl[0] = '{sm83_pkg::KIND_WRITE, hlv, ar[7:0], 5'd0}; n = 2'd1;
                            fin = 1'b1; cyc = 5'd16;
                        end
                    end
                    else if (op[7:6] == 2'b01)
                    begin
                        s = put_r(st, r, din); fin = 1'b1; cyc = 5'd8;
                    end
                    else if (op[7:6] == 2'b10)
                    begin
                        ar = arith(r, st.a, din, st.f);
                        s.a = ar[7:0]; s.f = ar[11:8];
                        fin = 1'b1; cyc = 5'd8;
                    end
                    else if ((op & 8'hC7) == 8'h04 || (op & 8'hC7) == 8'h05)
                    begin
                        if (sx3 == 3'd4)
                        begin
                            v8 = din + 8'd1;
                            s.f = {din == 8'hFF, 1'b0, din[3:0] == 4'hF, st.f[0]};
                        end
                        else
                        begin
                            v8 = din - 8'd1;
                            s.f = {din == 8'h01, 1'b1, din[3:0] == 4'h0, st.f[0]};
                        end
                        sl[0] = '{sm83_pkg::KIND_WRITE, hlv, v8, 5'd0}; n = 2'd1;
                        fin = 1'b1; cyc = 5'd12;
                    end
                    else if ((op & 8'hCF) == 8'hC1 || op == 8'hC9 || op == 8'hC0
                        || op == 8'hC8 || op == 8'hD0 || op == 8'hD8)
                    begin
                        s.opl = din;
                        sl[0] = '{sm83_pkg::KIND_READ, st.sp, 8'h0, 5'd0}; n = 2'd1;
                        s.sp = st.sp + 16'd1; s.phase = sm83_pkg::PH_DAT2;
                    end
                    else
                    begin
                        s.a = din; fin = 1'b1;
                        cyc = (op == 8'hFA) ? 5'd16 : ((op == 8'hF0) ? 5'd12 : 5'd8);
                    end
                end
                sm83_pkg::PH_DAT2:
                begin
                    if ((op & 8'hCF) == 8'hC1)
                    begin
                        if (p == 2'd3)
                        begin
                            s.a = din; s.f = st.opl[7:4];
                        end
                        else
                            s = pput(st, p, addr);
                        fin = 1'b1; cyc = 5'd12;
                    end
                    else
                    begin
                        s.pc = addr; fin = 1'b1;
                        cyc = (op == 8'hC9) ? 5'd16 : 5'd20;
                    end
                end
                default: s = st;
            endcase
        end

        if (fin)
        begin
            k = n;
            sl[k] = '{sm83_pkg::KIND_DONE, 16'h0, 8'h0, cyc};
            n = n + 2'd1;
            s.phase = sm83_pkg::PH_IDLE;
        end
        if (flt)
        begin
            sl[0] = '{sm83_pkg::KIND_FAULT, 16'h0, 8'h0, 5'd0};
            n = 2'd1;
            s = st;
            s.fault = 1'b1;
            s.phase = sm83_pkg::PH_IDLE;
            if (action == sm83_pkg::ACT_DELIVER)
                s.op = {1'b0, din};
        end
        ns = s;
    end

    assign slot0 = sl[0];
    assign slot1 = sl[1];
    assign slot2 = sl[2];
    assign count = n;

endmodule

### src/sm83_instruction_core.sv
// ----------------------------------------------------------------------------
// SM83 instruction core
// Top level: input register, execution step, result queue and APB port.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_stall/in_word. action 0 begins an instruction
//                 (opcode fetch request), action 1 delivers a read byte.
//   out channel : out_valid/out_stall/out_word. Each input word yields 0..3
//                 result words (read, write, done, fault); the final one has
//                 last set. Snapshots are filled on done and fault words.
//   APB port    : register 0 (boot_state) at byte address 0. Writing it
//                 reloads the register file at once (soft reset).
// Flow: an input word is registered, executed in one pass as soon as the result
// buffer is empty or its last word is leaving, and its results land in the
// three-entry result buffer, whose head word is presented on out_word.
// Throughput: words with one result flow at one per cycle while out_stall is
// low; a word that causes three results holds back the next word until they
// have left through the one-word-per-cycle output channel.
// Stall: out_stall holds the head word; the input word stays in the input
// register and in_stall stays high until the buffer's last word is taken.
// Reset: boot values loaded (PC 0x0100, SP 0xFFFE), no pending results.
// ----------------------------------------------------------------------------
module sm83_instruction_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sm83_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output sm83_pkg::out_word_t out_word,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    sm83_pkg::core_state_t st_reg;
    sm83_pkg::core_state_t st_next;
    logic                  boot_reg;

    // input register
    logic                  iv_reg;
    sm83_pkg::in_word_t    iw_reg;

    // result buffer: up to three words from one input word
    sm83_pkg::out_word_t   rb_reg [3];
    logic [1:0]            rcnt_reg;
    logic [1:0]            rhead_reg;

    sm83_pkg::res_slot_t   s0, s1, s2;
    logic [1:0]            cnt;
    logic                  cfg_wr;
    logic                  take_in;
    logic                  exec_go;
    logic                  pop;

    sm83_exec u_exec (
        .st     (st_reg),
        .action (iw_reg.action),
        .din    (iw_reg.read_data),
        .ns     (st_next),
        .slot0  (s0),
        .slot1  (s1),
        .slot2  (s2),
        .count  (cnt)
    );

    assign pready = 1'b1;
    assign prdata = {31'h0, boot_reg};
    assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == 2'b00)
        && (paddr[1] == sm83_pkg::ADDR_BOOT_STATE);

    // buffer empty (or emptying now) lets the registered word execute
    assign pop     = out_valid && !out_stall;
    assign exec_go = iv_reg && ((rcnt_reg == 2'd0) || ((rcnt_reg == 2'd1) && pop));
    assign in_stall = iv_reg && !exec_go;
    assign take_in = in_valid && !in_stall;

    assign out_valid = (rcnt_reg != 2'd0);
    assign out_word  = rb_reg[rhead_reg];

    function automatic sm83_pkg::out_word_t mk(input sm83_pkg::res_slot_t sl,
        input sm83_pkg::core_state_t s, input logic lst);
        sm83_pkg::out_word_t o;
        logic snap;
        snap = (sl.kind == sm83_pkg::KIND_DONE) || (sl.kind == sm83_pkg::KIND_FAULT);
        o.kind       = sl.kind;
        o.address    = sl.address;
        o.write_data = sl.write_data;
        o.cycles     = sl.cycles;
        o.last       = lst;
        o.snap_af    = snap ? {s.a, s.f, 4'h0} : 16'h0;
        o.snap_bc    = snap ? {s.b, s.c} : 16'h0;
        o.snap_de    = snap ? {s.d, s.e} : 16'h0;
        o.snap_hl    = snap ? {s.h, s.l} : 16'h0;
        o.snap_sp    = snap ? s.sp : 16'h0;
        o.snap_pc    = snap ? s.pc : 16'h0;
        return o;
    endfunction

    // snapshots show the state after the whole instruction; writes carry none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= sm83_pkg::init_state(1'b1);
            boot_reg  <= 1'b1;
            iv_reg    <= 1'b0;
            rcnt_reg  <= 2'd0;
            rhead_reg <= 2'd0;
        end
        else
        begin
            if (take_in)
                iv_reg <= 1'b1;
            else if (exec_go)
                iv_reg <= 1'b0;

            if (exec_go)
            begin
                st_reg    <= st_next;
                rcnt_reg  <= cnt;
                rhead_reg <= 2'd0;
            end
            else if (pop)
            begin
                rcnt_reg  <= rcnt_reg - 2'd1;
                rhead_reg <= rhead_reg + 2'd1;
            end

            if (cfg_wr)
            begin
                boot_reg <= pwdata[0];
                st_reg   <= sm83_pkg::init_state(pwdata[0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            iw_reg <= in_word;
        if (exec_go)
        begin
            rb_reg[0] <= mk(s0, st_next, cnt == 2'd1);
            rb_reg[1] <= mk(s1, st_next, cnt == 2'd2);
            rb_reg[2] <= mk(s2, st_next, cnt == 2'd3);
        end
    end

endmodule
